// ----- hw/rtl/tsfs_pkg.sv -----
// Shared types and constants for the time-slot frame scheduler.
`timescale 1ns / 1ps

package tsfs_pkg;

   // Scheduler sizing.
   localparam int NUM_HARTS       = 4;
   localparam int SLOTS_PER_CYCLE = 64;
   localparam int TICKS_PER_SLOT  = 1024;

   // Derived widths; harts, slots per cycle and ticks per slot are powers of two.
   localparam int HART_W     = $clog2(NUM_HARTS);
   localparam int SLOT_W     = $clog2(SLOTS_PER_CYCLE);
   localparam int TICK_SHIFT = $clog2(TICKS_PER_SLOT);
   localparam int ADDR_W     = HART_W + SLOT_W;
   localparam int DEPTH      = NUM_HARTS * SLOTS_PER_CYCLE;

   // Fixed field widths.
   localparam int MODE_W  = 2;
   localparam int OWNER_W = 16;
   localparam int LEN_W   = 7;
   localparam int END_W   = 7;
   localparam int CNT_W   = 64;

   // Reset contents of the frame table.
   localparam logic [LEN_W-1:0]   LEN_RESET         = LEN_W'(SLOTS_PER_CYCLE % 128);
   localparam logic [OWNER_W-1:0] OWNER_RESET       = 16'hFFFF;
   localparam logic [OWNER_W-1:0] OWNER_RESET_FIRST = 16'd1;
   localparam logic [OWNER_W-1:0] INVALID_OWNER_RST = 16'hFFFF;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_NEXT      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RECLAIM   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SPLIT     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SET_OWNER = 2'd3;

   // One accepted request.
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [HART_W-1:0]  hart;
      logic [OWNER_W-1:0] owner;
      logic [SLOT_W-1:0]  begin_slot;
      logic [SLOT_W-1:0]  middle_slot;
      logic [END_W-1:0]   end_slot;
      logic [CNT_W-1:0]   now_ticks;
   } item_type;

   // One frame table entry.
   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [LEN_W-1:0]   length;
   } frame_type;

   // Frame table access request.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      frame_type         wdata;
   } mem_req_type;

   // One response.
   typedef struct packed {
      logic [OWNER_W-1:0] run_owner;
      logic               owner_valid;
      logic [CNT_W-1:0]   timeout_if_run;
      logic [CNT_W-1:0]   timeout_if_idle;
      logic [CNT_W-1:0]   current_slot;
   } rsp_type;

endpackage

// ----- hw/rtl/tsfs_frame_mem.sv -----
// Frame table memory with per-entry valid bits that stand in for the reset contents.
`timescale 1ns / 1ps

module tsfs_frame_mem
   import tsfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output frame_type   rd_frame
);

   frame_type         frame_mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   frame_type         rd_raw_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr_ff;

   // Contents an entry holds before it is first written.
   function automatic frame_type reset_frame(input logic [ADDR_W-1:0] addr);
      frame_type f;
      f.owner  = (addr == '0) ? OWNER_RESET_FIRST : OWNER_RESET;
      f.length = (addr[SLOT_W-1:0] == '0) ? LEN_RESET : '0;
      return f;
   endfunction

   // Synchronous write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         frame_mem_ff[mem_req.addr] <= mem_req.wdata;
      end
   end

   // Valid bits are cleared at reset and set by the first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.addr] <= 1'b1;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_raw_ff   <= frame_mem_ff[mem_req.addr];
         rd_valid_ff <= valid_ff[mem_req.addr];
         rd_addr_ff  <= mem_req.addr;
      end
   end

   // Entries never written read as their reset contents.
   assign rd_frame = rd_valid_ff ? rd_raw_ff : reset_frame(rd_addr_ff);

endmodule

// ----- hw/rtl/tsfs_ctrl.sv -----
// Request sequencer: frame table read-modify-write and per-hart slot counters.
`timescale 1ns / 1ps

module tsfs_ctrl
   import tsfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  item_type           req_item,
   input  logic [OWNER_W-1:0] invalid_owner,
   input  logic               out_free,
   output logic               rsp_load,
   output rsp_type            rsp_data,
   output mem_req_type        mem_req,
   input  frame_type          rd_frame
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_SPLIT2 = 3'd2;
   localparam logic [2:0] ST_FINAL  = 3'd3;

   logic [2:0]        st_ff, st_in;
   item_type          item_ff;
   logic [CNT_W-1:0]  cnt_ff [NUM_HARTS];
   logic [CNT_W-1:0]  cnt_in;
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_cur;
   logic [CNT_W-1:0]  now_slot;
   logic [CNT_W-1:0]  adv_sum;
   logic [CNT_W-1:0]  split_target;
   logic [SLOT_W-1:0] pos;
   logic [SLOT_W-1:0] req_pos;

   // Current hart's counter and derived values.
   assign cnt_cur      = cnt_ff[item_ff.hart];
   assign pos          = cnt_cur[SLOT_W-1:0];
   assign now_slot     = item_ff.now_ticks >> TICK_SHIFT;
   assign adv_sum      = cnt_cur + CNT_W'(rd_frame.length);
   assign split_target = cnt_cur + CNT_W'(item_ff.middle_slot) - CNT_W'(item_ff.begin_slot);
   assign req_pos      = (req_item.mode == MODE_NEXT) ?
                         cnt_ff[req_item.hart][SLOT_W-1:0] : req_item.begin_slot;

   // Sequencer.
   always_comb begin
      st_in     = st_ff;
      req_ready = 1'b0;
      mem_req   = '0;
      cnt_we    = 1'b0;
      cnt_in    = cnt_cur;
      rsp_load  = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_req.rd_en = 1'b1;
               mem_req.addr  = {req_item.hart, req_pos};
               st_in         = ST_EVAL;
            end
         end
         ST_EVAL: begin
            st_in = ST_FINAL;
            unique case (item_ff.mode)
               MODE_NEXT: begin
                  // Step past an expired frame and fetch the frame it lands on.
                  if (adv_sum <= now_slot) begin
                     cnt_we        = 1'b1;
                     cnt_in        = adv_sum;
                     mem_req.rd_en = 1'b1;
                     mem_req.addr  = {item_ff.hart, adv_sum[SLOT_W-1:0]};
                  end
               end
               MODE_RECLAIM: begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.addr         = {item_ff.hart, item_ff.begin_slot};
                  mem_req.wdata.owner  = item_ff.owner;
                  mem_req.wdata.length = LEN_W'(item_ff.end_slot - {1'b0, item_ff.begin_slot});
                  // Pull the counter back to the start of the reclaimed range.
                  if ((item_ff.begin_slot <= pos) && ({1'b0, pos} < item_ff.end_slot)) begin
                     cnt_we = 1'b1;
                     cnt_in = cnt_cur - CNT_W'(pos - item_ff.begin_slot);
                  end
               end
               MODE_SPLIT: begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.addr         = {item_ff.hart, item_ff.begin_slot};
                  mem_req.wdata.owner  = rd_frame.owner;
                  mem_req.wdata.length = LEN_W'({1'b0, item_ff.middle_slot}
                                                - {1'b0, item_ff.begin_slot});
                  // Jump to the new frame if the counter sits at the split frame and the target is past.
                  if ((pos == item_ff.begin_slot) && (split_target < now_slot)) begin
                     cnt_we = 1'b1;
                     cnt_in = split_target;
                  end
                  st_in = ST_SPLIT2;
               end
               MODE_SET_OWNER: begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.addr         = {item_ff.hart, item_ff.begin_slot};
                  mem_req.wdata.owner  = item_ff.owner;
                  mem_req.wdata.length = rd_frame.length;
               end
               default: begin
                  st_in = ST_FINAL;
               end
            endcase
         end
         ST_SPLIT2: begin
            // Second half of a split: the new owner's frame.
            mem_req.wr_en        = 1'b1;
            mem_req.addr         = {item_ff.hart, item_ff.middle_slot};
            mem_req.wdata.owner  = item_ff.owner;
            mem_req.wdata.length = LEN_W'(item_ff.end_slot - {1'b0, item_ff.middle_slot});
            st_in                = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Response fields; only mode next reports a frame.
   always_comb begin
      rsp_data              = '0;
      rsp_data.current_slot = cnt_cur;
      if (item_ff.mode == MODE_NEXT) begin
         rsp_data.run_owner       = rd_frame.owner;
         rsp_data.owner_valid     = (rd_frame.owner != invalid_owner);
         rsp_data.timeout_if_run  = (cnt_cur + CNT_W'(rd_frame.length)) << TICK_SHIFT;
         rsp_data.timeout_if_idle = (cnt_cur + CNT_W'(1)) << TICK_SHIFT;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   // Slot counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HARTS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[item_ff.hart] <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/time_slot_frame_scheduler.sv -----
// Top level of the time-slot frame scheduler: ports, config register and response register.
`timescale 1ns / 1ps
//
// Usage:
// A request transaction on the req_ channel (valid/ready) carries a mode, a hart and
// the slot and owner fields. Mode next advances the hart's slot counter past an
// expired frame and reports the frame owner and both timeouts; reclaim, split and
// set-owner rewrite the hart's frame table. Every request gives exactly one response
// transaction on the rsp_ channel, in order.
// An accepted request passes an evaluate step, a second write step for split only,
// and a final step that loads the response register; requests are handled one at a time.
// The frame table is one single-port memory with a registered read: each request reads
// first, then mode next may read again, reclaim and set-owner write back once, split twice.
// The response sits in an output register, so a new request is taken while an
// earlier response waits; a stalled receiver holds the block in its final step.
// csr_wr_en writes invalid_owner from csr_wr_data at once; write it only when idle.
// Reset (synchronous) empties the pipeline, zeroes all slot counters, sets
// invalid_owner to 0xFFFF and restores the frame table to its initial contents
// without a clearing pass: the block takes requests right after reset.

module time_slot_frame_scheduler
   import tsfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_hart,
   input  logic [15:0]        req_owner,
   input  logic [5:0]         req_begin_slot,
   input  logic [5:0]         req_middle_slot,
   input  logic [6:0]         req_end_slot,
   input  logic [63:0]        req_now_ticks,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_run_owner,
   output logic               rsp_owner_valid,
   output logic [63:0]        rsp_timeout_if_run,
   output logic [63:0]        rsp_timeout_if_idle,
   output logic [63:0]        rsp_current_slot,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   item_type           req_item;
   mem_req_type        mem_req;
   frame_type          rd_frame;
   rsp_type            rsp_data;
   rsp_type            rsp_ff;
   logic               rsp_load;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OWNER_W-1:0] invalid_owner_ff;

   // Request fields, reduced to table index ranges.
   always_comb begin
      req_item.mode        = req_mode;
      req_item.hart        = req_hart[HART_W-1:0];
      req_item.owner       = req_owner;
      req_item.begin_slot  = req_begin_slot[SLOT_W-1:0];
      req_item.middle_slot = req_middle_slot[SLOT_W-1:0];
      req_item.end_slot    = req_end_slot;
      req_item.now_ticks   = req_now_ticks;
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_owner_ff <= INVALID_OWNER_RST;
      end else if (csr_wr_en) begin
         invalid_owner_ff <= csr_wr_data;
      end
   end

   tsfs_frame_mem u_frame_mem (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_frame (rd_frame)
   );

   tsfs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .invalid_owner (invalid_owner_ff),
      .out_free      (out_free),
      .rsp_load      (rsp_load),
      .rsp_data      (rsp_data),
      .mem_req       (mem_req),
      .rd_frame      (rd_frame)
   );

   // Response register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_owner       = rsp_ff.run_owner;
   assign rsp_owner_valid     = rsp_ff.owner_valid;
   assign rsp_timeout_if_run  = rsp_ff.timeout_if_run;
   assign rsp_timeout_if_idle = rsp_ff.timeout_if_idle;
   assign rsp_current_slot    = rsp_ff.current_slot;

endmodule

// ----- tb/time_slot_frame_scheduler_test.sv -----
// Self-checking testbench for the time-slot frame scheduler: directed and random requests.
`timescale 1ns / 1ps

module time_slot_frame_scheduler_test;
   import tsfs_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [1:0]         req_hart;
   logic [15:0]        req_owner;
   logic [5:0]         req_begin_slot;
   logic [5:0]         req_middle_slot;
   logic [6:0]         req_end_slot;
   logic [63:0]        req_now_ticks;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_run_owner;
   logic               rsp_owner_valid;
   logic [63:0]        rsp_timeout_if_run;
   logic [63:0]        rsp_timeout_if_idle;
   logic [63:0]        rsp_current_slot;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   // Predicted scheduler state: frame tables, slot counters and the "no process" code.
   logic [OWNER_W-1:0] table_owner [NUM_HARTS][SLOTS_PER_CYCLE];
   logic [LEN_W-1:0]   table_len [NUM_HARTS][SLOTS_PER_CYCLE];
   logic [CNT_W-1:0]   hart_slot [NUM_HARTS];
   logic [OWNER_W-1:0] no_owner_code;

   // Reports still owed by the block, oldest first.
   rsp_type            awaited_reports [$];
   int                 failure_count;
   bit                 bursts_on;
   int                 hold_off_cycles;

   time_slot_frame_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_hart            (req_hart),
      .req_owner           (req_owner),
      .req_begin_slot      (req_begin_slot),
      .req_middle_slot     (req_middle_slot),
      .req_end_slot        (req_end_slot),
      .req_now_ticks       (req_now_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_run_owner       (rsp_run_owner),
      .rsp_owner_valid     (rsp_owner_valid),
      .rsp_timeout_if_run  (rsp_timeout_if_run),
      .rsp_timeout_if_idle (rsp_timeout_if_idle),
      .rsp_current_slot    (rsp_current_slot),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Put the predicted tables and counters in their power-on state.
   task automatic reset_schedule();
      for (int h = 0; h < NUM_HARTS; h++) begin
         for (int s = 0; s < SLOTS_PER_CYCLE; s++) begin
            table_owner[h][s] = OWNER_RESET;
            table_len[h][s]   = '0;
         end
         table_len[h][0] = LEN_RESET;
         hart_slot[h]    = '0;
      end
      table_owner[0][0] = OWNER_RESET_FIRST;
      no_owner_code     = INVALID_OWNER_RST;
   endtask

   // Apply one request to the predicted state and return the report it produces.
   function automatic rsp_type schedule_report(item_type rq);
      rsp_type           rs;
      logic [CNT_W-1:0]  now_slot;
      logic [CNT_W-1:0]  target;
      logic [SLOT_W-1:0] pos;
      logic [OWNER_W-1:0] fo;
      logic [LEN_W-1:0]  fl;
      int unsigned       h, b, m, e;
      rs       = '0;
      h        = rq.hart;
      b        = rq.begin_slot;
      m        = rq.middle_slot;
      e        = rq.end_slot;
      now_slot = rq.now_ticks >> TICK_SHIFT;
      case (rq.mode)
         MODE_NEXT: begin
            // Step past the current frame only once it has fully expired.
            pos = hart_slot[h][SLOT_W-1:0];
            fl  = table_len[h][pos];
            if (hart_slot[h] + CNT_W'(fl) <= now_slot) begin
               hart_slot[h] = hart_slot[h] + CNT_W'(fl);
            end
            pos = hart_slot[h][SLOT_W-1:0];
            fo  = table_owner[h][pos];
            fl  = table_len[h][pos];
            rs.run_owner       = fo;
            rs.owner_valid     = (fo != no_owner_code);
            rs.timeout_if_idle = (hart_slot[h] + CNT_W'(1)) << TICK_SHIFT;
            rs.timeout_if_run  = (hart_slot[h] + CNT_W'(fl)) << TICK_SHIFT;
         end
         MODE_RECLAIM: begin
            // A counter inside the reclaimed range falls back to its start.
            table_owner[h][b] = rq.owner;
            table_len[h][b]   = LEN_W'(e - b);
            pos = hart_slot[h][SLOT_W-1:0];
            if (b <= pos && pos < e) begin
               hart_slot[h] = hart_slot[h] - CNT_W'(pos - b);
            end
         end
         MODE_SPLIT: begin
            // The counter jumps to the split point if it sits on the split frame and the target is past.
            table_len[h][b]   = LEN_W'(m - b);
            table_owner[h][m] = rq.owner;
            table_len[h][m]   = LEN_W'(e - m);
            if (hart_slot[h][SLOT_W-1:0] == b) begin
               target = hart_slot[h] + CNT_W'(m) - CNT_W'(b);
               if (target < now_slot) begin
                  hart_slot[h] = target;
               end
            end
         end
         default: begin
            table_owner[h][b] = rq.owner;
         end
      endcase
      rs.current_slot = hart_slot[h];
      return rs;
   endfunction

   function automatic item_type make_request(logic [MODE_W-1:0] mode, int unsigned hart,
                                             int unsigned owner, int unsigned b,
                                             int unsigned m, int unsigned e,
                                             logic [CNT_W-1:0] now);
      item_type rq;
      rq.mode        = mode;
      rq.hart        = HART_W'(hart);
      rq.owner       = OWNER_W'(owner);
      rq.begin_slot  = SLOT_W'(b);
      rq.middle_slot = SLOT_W'(m);
      rq.end_slot    = END_W'(e);
      rq.now_ticks   = now;
      return rq;
   endfunction

   // Tick values mostly from 4 slots before to 136 slots after a counter, so frames expire or not.
   function automatic logic [CNT_W-1:0] ticks_near(logic [CNT_W-1:0] slot);
      logic [CNT_W-1:0] base;
      int unsigned      pick;
      pick = $urandom_range(0, 39);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      if (pick < 6) return {$urandom, $urandom};
      base = slot + CNT_W'($urandom_range(0, 140)) - CNT_W'(4);
      return (base << TICK_SHIFT) | CNT_W'($urandom_range(0, TICKS_PER_SLOT - 1));
   endfunction

   // Random request shaped by the predicted state of the chosen hart.
   function automatic item_type random_request();
      item_type         rq;
      logic [CNT_W-1:0] cnt;
      int unsigned      h, pick, b, m;
      h    = $urandom_range(0, NUM_HARTS - 1);
      cnt  = hart_slot[h];
      pick = $urandom_range(0, 99);
      rq   = make_request(MODE_NEXT, h, $urandom, $urandom, $urandom,
                          $urandom_range(1, SLOTS_PER_CYCLE), ticks_near(cnt));
      case ($urandom_range(0, 7))
         0: rq.owner = no_owner_code;
         1: rq.owner = OWNER_W'($urandom_range(0, 3));
         default: ;
      endcase
      if (pick < 50) begin
         rq.mode = MODE_NEXT;
      end else if (pick < 72) begin
         // Split mostly the frame the counter is in, with the split point mostly at or after it.
         rq.mode = MODE_SPLIT;
         b = ($urandom_range(0, 2) != 0) ? int'(cnt[SLOT_W-1:0])
                                          : $urandom_range(0, SLOTS_PER_CYCLE - 1);
         m = ($urandom_range(0, 4) != 0) ? $urandom_range(b, SLOTS_PER_CYCLE - 1)
                                          : $urandom_range(0, SLOTS_PER_CYCLE - 1);
         rq.begin_slot  = SLOT_W'(b);
         rq.middle_slot = SLOT_W'(m);
         if ($urandom_range(0, 4) != 0) begin
            rq.end_slot = END_W'($urandom_range(m + 1, SLOTS_PER_CYCLE));
         end
      end else if (pick < 87) begin
         // Reclaim, half the time, a range that begins at or before the counter's position.
         rq.mode = MODE_RECLAIM;
         b = ($urandom_range(0, 1) != 0) ? $urandom_range(0, cnt[SLOT_W-1:0])
                                          : $urandom_range(0, SLOTS_PER_CYCLE - 1);
         rq.begin_slot = SLOT_W'(b);
         rq.end_slot   = END_W'($urandom_range(b + 1, SLOTS_PER_CYCLE));
      end else begin
         rq.mode = MODE_SET_OWNER;
      end
      if ($urandom_range(0, 11) == 0) begin
         rq.end_slot = END_W'($urandom);
      end
      return rq;
   endfunction

   // Offer one request transaction and record its report once it is taken.
   task automatic send_request(input item_type rq);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= rq.mode;
      req_hart        <= rq.hart;
      req_owner       <= rq.owner;
      req_begin_slot  <= rq.begin_slot;
      req_middle_slot <= rq.middle_slot;
      req_end_slot    <= rq.end_slot;
      req_now_ticks   <= rq.now_ticks;
      do @(posedge clock); while (!req_ready);
      awaited_reports.push_back(schedule_report(rq));
   endtask

   // Let the block drain, then write the no-process owner code.
   task automatic write_no_owner_code(input logic [OWNER_W-1:0] code);
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      no_owner_code = code;
   endtask

   // Initial frames of every hart, and the first advance from reset.
   task automatic test_reset_frames();
      for (int h = 0; h < NUM_HARTS; h++) begin
         send_request(make_request(MODE_NEXT, h, 0, 0, 0, 1, '0));
      end
      send_request(make_request(MODE_NEXT, 0, 0, 0, 0, 1, CNT_W'(SLOTS_PER_CYCLE) << TICK_SHIFT));
      send_request(make_request(MODE_NEXT, 1, 0, 0, 0, 1, '1));
   endtask

   // Write modes with extreme fields, wrapped lengths and counter moves.
   task automatic test_write_modes();
      send_request(make_request(MODE_RECLAIM, 2, 0, 0, 0, SLOTS_PER_CYCLE, '0));
      send_request(make_request(MODE_SET_OWNER, 3, 16'hFFFF, 63, 63, 127, '1));
      // Zero-length frame: the counter must stay put even with time far ahead.
      send_request(make_request(MODE_RECLAIM, 3, 5, 0, 0, 0, '0));
      send_request(make_request(MODE_NEXT, 3, 0, 0, 0, 1, '1));
      // End before begin wraps the stored length.
      send_request(make_request(MODE_RECLAIM, 2, 3, 1, 0, 0, '0));
      send_request(make_request(MODE_SPLIT, 1, 7, 0, 40, SLOTS_PER_CYCLE, '1));
      // Middle before begin moves the counter backward.
      send_request(make_request(MODE_SPLIT, 1, 8, 40, 10, 127, '1));
      send_request(make_request(MODE_NEXT, 1, 0, 0, 0, 1, CNT_W'(74) << TICK_SHIFT));
      send_request(make_request(MODE_NEXT, 1, 0, 0, 0, 1, '1));
      send_request(make_request(MODE_RECLAIM, 1, 9, 60, 0, SLOTS_PER_CYCLE, '0));
      // Split on the current frame whose target is not yet in the past.
      send_request(make_request(MODE_SPLIT, 0, 2, 0, 63, SLOTS_PER_CYCLE, '0));
      send_request(make_request(MODE_NEXT, 2, 0, 0, 0, 1, '0));
      send_request(make_request(MODE_NEXT, 0, 0, 0, 0, 1, 64'h8000_0000_0000_0000));
      send_request(make_request(MODE_SET_OWNER, 0, 0, 0, 0, 1, '0));
   endtask

   // A new no-process code changes validity without touching stored owners.
   task automatic test_owner_register();
      write_no_owner_code('0);
      send_request(make_request(MODE_NEXT, 2, 0, 0, 0, 1, '0));
      send_request(make_request(MODE_NEXT, 1, 0, 0, 0, 1, '0));
      send_request(make_request(MODE_NEXT, 0, 0, 0, 0, 1, '0));
   endtask

   // Receiver holds off while requests keep coming, so the block fills and stalls.
   task automatic test_full_output_stall();
      bursts_on       = 1'b0;
      hold_off_cycles = 150;
      repeat (24) send_request(random_request());
   endtask

   // Random traffic with idle bursts and a new owner code per phase.
   task automatic test_random_traffic(input int count);
      bursts_on = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i % 190 == 0) begin
            case ((i / 190) % 3)
               0: write_no_owner_code(OWNER_W'($urandom));
               1: write_no_owner_code(16'hFFFF);
               default: write_no_owner_code(16'h0001);
            endcase
         end
         send_request(random_request());
      end
   endtask

   // Back-to-back traffic with both sides always ready.
   task automatic test_calm_traffic(input int count);
      write_no_owner_code(16'hFFFF);
      bursts_on = 1'b0;
      repeat (count) send_request(random_request());
   endtask

   // Receiver: random ready bursts, plus a long hold-off on request.
   initial begin : receiver
      int stretch;
      rsp_ready <= 1'b0;
      forever begin
         if (hold_off_cycles != 0) begin
            stretch         = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (stretch) @(posedge clock);
         end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic void check_field(string field, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         failure_count++;
      end
   endfunction

   // Compare each accepted response transaction with the oldest predicted report.
   always @(posedge clock) begin : report_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("response transaction with no report awaited");
            failure_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("run_owner", CNT_W'(want.run_owner), CNT_W'(rsp_run_owner));
            check_field("owner_valid", CNT_W'(want.owner_valid), CNT_W'(rsp_owner_valid));
            check_field("timeout_if_run", want.timeout_if_run, rsp_timeout_if_run);
            check_field("timeout_if_idle", want.timeout_if_idle, rsp_timeout_if_idle);
            check_field("current_slot", want.current_slot, rsp_current_slot);
         end
      end
   end

   // Test sequence.
   initial begin
      failure_count   = 0;
      bursts_on       = 1'b0;
      hold_off_cycles = 0;
      reset_schedule();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_NEXT;
      req_hart        <= '0;
      req_owner       <= '0;
      req_begin_slot  <= '0;
      req_middle_slot <= '0;
      req_end_slot    <= '0;
      req_now_ticks   <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_frames();
      test_write_modes();
      test_owner_register();
      test_full_output_stall();
      test_random_traffic(740);
      test_calm_traffic(110);

      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failure_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
